// ----- rtl/bta_pkg.sv -----
// Shared types and constants for the bakery ticket arbiter.
package bta_pkg;

   // Request channel field widths.
   localparam int FUNC_W      = 1;
   localparam int THREAD_ID_W = 3;
   localparam int REQ_DATA_W  = 8;

   // Response channel field widths and packing.
   localparam int OWNER_ID_W  = 3;
   localparam int TICKET_W    = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USED_W  = 1 + OWNER_ID_W + TICKET_W + 1 + 1;

   // Configuration port.
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int THREAD_COUNT_W    = 4;
   localparam logic [THREAD_COUNT_W-1:0] THREAD_COUNT_RESET = 4'd8;

   // Register index taken from the word address.
   localparam logic [CSR_ADDR_W-3:0] REG_THREAD_COUNT = 1'b0;

   // Request kinds carried in tuser.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_REQUEST = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

endpackage

// ----- rtl/bakery_ticket_arbiter_top.sv -----
// Bakery ticket arbiter: first-come-first-served lock arbitration over a ticket table.
//
// Each request-channel transaction is a lock request or release from one requester
// and produces one response transaction that reports the current owner (the wanting
// requester with the least ticket, ties to the lower number), the ticket given by a
// request, and flags for ignored requesters and saturated tickets. The ticket and
// wanting tables live in single-port synchronous RAMs and are swept one entry per
// cycle through the single read port, which serves both the largest-ticket scan and
// the owner scan. A new transaction is taken while the previous response still waits
// in the output register. Tables read as zero after reset through per-entry valid
// bits, so no clearing pass is needed.
module bakery_ticket_arbiter_top
   import bta_pkg::*;
#(
   parameter int MAX_THREADS = 8,
   parameter int LABEL_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_W-1:0]     req_tdata,  // [2:0] thread_id, [7:3] zero
   input  logic [FUNC_W-1:0]         req_tuser,  // [0] func
   // Response channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [0] owner_valid, [3:1] owner_id, [19:4] ticket_given, [20] ignored,
   // [21] ticket_saturated, [23:22] zero
   output logic [RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration port.
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   localparam int IDX_W = $clog2(MAX_THREADS);
   localparam int CNT_W = $clog2(MAX_THREADS + 1);
   localparam logic [LABEL_BITS-1:0] LABEL_MAX = {LABEL_BITS{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAX_SCAN,
      ST_WRITE,
      ST_OWN_SCAN,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic [THREAD_COUNT_W-1:0] thread_count_ff;

   // Latched transaction.
   func_type                func_ff;
   logic [IDX_W-1:0]        tid_ff;
   logic [CNT_W-1:0]        n_ff;
   logic                    ign_ff;

   // Scan control and accumulators.
   logic [CNT_W-1:0]        issue_ff;
   logic                    pend_ff;
   logic [IDX_W-1:0]        pend_idx_ff;
   logic [LABEL_BITS-1:0]   top_ff;
   logic [LABEL_BITS-1:0]   given_ff;
   logic                    sat_ff;
   logic                    found_ff;
   logic [IDX_W-1:0]        best_ff;
   logic [LABEL_BITS-1:0]   best_tick_ff;

   // Output register.
   logic                    rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff;

   // Memories and their valid bits.
   logic [LABEL_BITS-1:0]   ticket_mem [MAX_THREADS];
   logic                    want_mem   [MAX_THREADS];
   logic [MAX_THREADS-1:0]  tick_vld_ff;
   logic [MAX_THREADS-1:0]  want_vld_ff;
   logic [LABEL_BITS-1:0]   rd_tick_ff;
   logic                    rd_want_ff;
   logic                    rd_tick_vld_ff;
   logic                    rd_want_vld_ff;

   logic [IDX_W-1:0]        rd_addr;
   logic [LABEL_BITS-1:0]   tick_eff;
   logic                    want_eff;
   logic                    issue_more;
   logic                    scan_done;
   logic [CNT_W-1:0]        n_in;
   logic [IDX_W-1:0]        tid_in;
   logic                    ign_in;
   logic [LABEL_BITS-1:0]   given_in;
   logic                    sat_in;
   logic                    csr_wr;
   logic                    rsp_load;

   // Configuration register access.
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;
   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1:2] == REG_THREAD_COUNT) begin
         prdata = CSR_DATA_W'(thread_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thread_count_ff <= THREAD_COUNT_RESET;
      end else if (csr_wr && paddr[CSR_ADDR_W-1:2] == REG_THREAD_COUNT) begin
         thread_count_ff <= pwdata[THREAD_COUNT_W-1:0];
      end
   end

   // Decode of the incoming transaction.
   assign n_in   = (32'(thread_count_ff) < 32'(MAX_THREADS)) ?
                   CNT_W'(thread_count_ff) : CNT_W'(MAX_THREADS);
   assign tid_in = IDX_W'(req_tdata[THREAD_ID_W-1:0]);
   assign ign_in = 32'(req_tdata[THREAD_ID_W-1:0]) >= 32'(n_in);

   // Next ticket, held at the label maximum.
   assign sat_in   = (top_ff == LABEL_MAX);
   assign given_in = sat_in ? LABEL_MAX : top_ff + 1'b1;

   // Sweep control: one table read issued per cycle, its data registered for the next cycle.
   assign rd_addr    = issue_ff[IDX_W-1:0];
   assign issue_more = issue_ff < n_ff;
   assign scan_done  = !issue_more && !pend_ff;
   assign tick_eff   = rd_tick_vld_ff ? rd_tick_ff : '0;
   assign want_eff   = rd_want_vld_ff & rd_want_ff;

   // The response register loads once the sweep is done and its slot is free.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Table memories: written in the write step, read every cycle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE && func_ff == FUNC_REQUEST) begin
         ticket_mem[tid_ff] <= given_in;
      end
      if (state_ff == ST_WRITE) begin
         want_mem[tid_ff] <= (func_ff == FUNC_REQUEST);
      end
      rd_tick_ff <= ticket_mem[rd_addr];
      rd_want_ff <= want_mem[rd_addr];
   end

   // Valid bits make unwritten entries read as zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_vld_ff    <= '0;
         want_vld_ff    <= '0;
         rd_tick_vld_ff <= 1'b0;
         rd_want_vld_ff <= 1'b0;
      end else begin
         if (state_ff == ST_WRITE && func_ff == FUNC_REQUEST) begin
            tick_vld_ff[tid_ff] <= 1'b1;
         end
         if (state_ff == ST_WRITE) begin
            want_vld_ff[tid_ff] <= 1'b1;
         end
         rd_tick_vld_ff <= tick_vld_ff[rd_addr];
         rd_want_vld_ff <= want_vld_ff[rd_addr];
      end
   end

   // Sequencer with its registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !rsp_load) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  func_ff      <= func_type'(req_tuser);
                  tid_ff       <= tid_in;
                  n_ff         <= n_in;
                  ign_ff       <= ign_in;
                  issue_ff     <= '0;
                  pend_ff      <= 1'b0;
                  top_ff       <= '0;
                  given_ff     <= '0;
                  sat_ff       <= 1'b0;
                  found_ff     <= 1'b0;
                  best_ff      <= '0;
                  best_tick_ff <= '0;
                  if (ign_in) begin
                     state_ff <= ST_OWN_SCAN;
                  end else if (func_type'(req_tuser) == FUNC_REQUEST) begin
                     state_ff <= ST_MAX_SCAN;
                  end else begin
                     state_ff <= ST_WRITE;
                  end
               end
            end
            ST_MAX_SCAN: begin
               // Largest ticket among the active entries.
               if (issue_more) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               pend_ff     <= issue_more;
               pend_idx_ff <= rd_addr;
               if (pend_ff && tick_eff > top_ff) begin
                  top_ff <= tick_eff;
               end
               if (scan_done) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               if (func_ff == FUNC_REQUEST) begin
                  given_ff <= given_in;
                  sat_ff   <= sat_in;
               end
               issue_ff <= '0;
               pend_ff  <= 1'b0;
               state_ff <= ST_OWN_SCAN;
            end
            ST_OWN_SCAN: begin
               // Wanting entry with the least ticket; strict compare keeps the lower number.
               if (issue_more) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               pend_ff     <= issue_more;
               pend_idx_ff <= rd_addr;
               if (pend_ff && want_eff && (!found_ff || tick_eff < best_tick_ff)) begin
                  found_ff     <= 1'b1;
                  best_ff      <= pend_idx_ff;
                  best_tick_ff <= tick_eff;
               end
               if (scan_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= RSP_DATA_W'({sat_ff, ign_ff, TICKET_W'(given_ff),
                                                OWNER_ID_W'(found_ff ? best_ff : '0),
                                                found_ff});
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // An ignored transaction never reaches the table write.
   a_ignored_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> !ign_ff)
      else $error("table write for an ignored transaction");

   // The sweep never runs past the active requester count.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAX_SCAN || state_ff == ST_OWN_SCAN) |-> (issue_ff <= n_ff))
      else $error("table sweep ran past the active count");

   // An ignored response carries neither a ticket nor a saturation flag.
   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[20]) |-> (rsp_tdata_ff[19:4] == '0 && !rsp_tdata_ff[21]))
      else $error("ignored response carries a ticket");

   // A saturated ticket is the label maximum.
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[21]) |-> (rsp_tdata_ff[19:4] == TICKET_W'(LABEL_MAX)))
      else $error("saturated ticket differs from the label maximum");

endmodule

// ----- tb/tb_bakery_ticket_arbiter_top.sv -----
// Self-checking testbench for the bakery ticket arbiter: lock traffic, register settings, stale tickets.
module tb_bakery_ticket_arbiter_top;
   import bta_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_THREADS = 8;
   localparam logic [TICKET_W-1:0] TICKET_MAX = '1;
   localparam logic [CSR_ADDR_W-1:0] THREAD_COUNT_ADDR = {REG_THREAD_COUNT, 2'b00};
   // Word address just past the register list; writes there must be dropped.
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;
   localparam int MAX_PRINTED = 30;
   localparam int HOLD_OFF_CYCLES = 400;

   // One owner report, packed as it travels in rsp_tdata.
   typedef struct packed {
      logic                  ticket_saturated;
      logic                  ignored;
      logic [TICKET_W-1:0]   ticket_given;
      logic [OWNER_ID_W-1:0] owner_id;
      logic                  owner_valid;
   } owner_report_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [2:0] thread_id, [7:3] zero
   logic [FUNC_W-1:0]     req_tuser;   // [0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [0] owner_valid, [3:1] owner_id, [19:4] ticket_given, [20] ignored,
   // [21] ticket_saturated, [23:22] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Mirror of the arbiter state and its register.
   logic                  wants_lock [NUM_THREADS];
   logic [TICKET_W-1:0]   held_ticket [NUM_THREADS];
   logic [THREAD_COUNT_W-1:0] cfg_thread_count;

   owner_report_t pending_reports [$];

   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   logic        holding_off;
   event        hold_off_start;

   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned ignored_items = 0;
   int unsigned saturated_tickets = 0;
   int unsigned register_writes = 0;
   int unsigned input_stall_cycles = 0;

   bakery_ticket_arbiter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   // Free-running 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run time limit, well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // Print one line per mismatch (up to a cap) and count every one.
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (error_count < MAX_PRINTED)
         $display("mismatch at %0t ns: %s is %0d, should be %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic int unsigned active_threads();
      return (cfg_thread_count > NUM_THREADS) ? NUM_THREADS : cfg_thread_count;
   endfunction

   // Apply one lock transaction to the mirror and work out the owner report it causes.
   function automatic owner_report_t predict_owner_report(input func_type f,
                                                          input logic [2:0] tid);
      owner_report_t       rep;
      int unsigned         active;
      logic [TICKET_W-1:0] top;
      logic                found;
      logic [2:0]          best;
      rep = '0;
      active = active_threads();
      top = '0;
      found = 1'b0;
      best = '0;
      if (tid >= active) begin
         rep.ignored = 1'b1;
      end else if (f == FUNC_REQUEST) begin
         wants_lock[tid] = 1'b1;
         for (int k = 0; k < active; k++)
            if (held_ticket[k] > top) top = held_ticket[k];
         if (top == TICKET_MAX) begin
            rep.ticket_given = TICKET_MAX;
            rep.ticket_saturated = 1'b1;
         end else begin
            rep.ticket_given = top + 1'b1;
         end
         held_ticket[tid] = rep.ticket_given;
      end else begin
         wants_lock[tid] = 1'b0;
      end
      // Least ticket among wanting active requesters, ties to the lower number.
      for (int k = 0; k < active; k++) begin
         if (wants_lock[k] && (!found || held_ticket[k] < held_ticket[best])) begin
            best = k[2:0];
            found = 1'b1;
         end
      end
      rep.owner_valid = found;
      rep.owner_id = found ? best : '0;
      return rep;
   endfunction

   // Offer one lock transaction after a random gap and log its prediction on acceptance.
   task automatic send_item(input func_type f, input logic [2:0] tid);
      owner_report_t rep;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {{(REQ_DATA_W - THREAD_ID_W){1'b0}}, tid};
      do @(posedge clock); while (!req_tready);
      rep = predict_owner_report(f, tid);
      pending_reports.push_back(rep);
      items_sent++;
      if (rep.ignored) ignored_items++;
      if (rep.ticket_saturated) saturated_tickets++;
   endtask

   // Stop offering and wait until every owner report has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // One register transfer: setup cycle, then access until pready.
   task automatic apb_transfer(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   // Read the thread count register, compare it, and return the port to idle.
   task automatic read_back_thread_count();
      logic [CSR_DATA_W-1:0] rdata;
      apb_transfer(1'b0, THREAD_COUNT_ADDR, '0, rdata);
      if (rdata !== CSR_DATA_W'(cfg_thread_count))
         report_mismatch("thread_count readback", rdata, cfg_thread_count);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Register write, only with the arbiter idle, followed by a readback.
   task automatic set_register(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] unused;
      wait_idle();
      apb_transfer(1'b1, addr, value, unused);
      if (addr == THREAD_COUNT_ADDR) cfg_thread_count = value[THREAD_COUNT_W-1:0];
      register_writes++;
      read_back_thread_count();
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
   endtask

   // Long receiver hold-off, counted in cycles here once a test asks for it.
   initial begin
      holding_off = 1'b0;
      forever begin
         @(hold_off_start);
         holding_off <= 1'b1;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         holding_off <= 1'b0;
      end
   end

   // Response side: random ready, or held off during a long stretch.
   always @(posedge clock) begin
      if (holding_off) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Compare each accepted owner report with the oldest prediction.
   always @(posedge clock) begin
      owner_report_t seen;
      owner_report_t want;
      if (!reset) begin
         if (req_tvalid && !req_tready) input_stall_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            seen = owner_report_t'(rsp_tdata[RSP_USED_W-1:0]);
            if (rsp_tdata[RSP_DATA_W-1:RSP_USED_W] != '0)
               report_mismatch("rsp_tdata padding", rsp_tdata[RSP_DATA_W-1:RSP_USED_W], 0);
            if (pending_reports.size() == 0) begin
               report_mismatch("unexpected owner report", 1, 0);
            end else begin
               want = pending_reports.pop_front();
               if (seen.owner_valid !== want.owner_valid)
                  report_mismatch("owner_valid", seen.owner_valid, want.owner_valid);
               if (seen.owner_id !== want.owner_id)
                  report_mismatch("owner_id", seen.owner_id, want.owner_id);
               if (seen.ticket_given !== want.ticket_given)
                  report_mismatch("ticket_given", seen.ticket_given, want.ticket_given);
               if (seen.ignored !== want.ignored)
                  report_mismatch("ignored", seen.ignored, want.ignored);
               if (seen.ticket_saturated !== want.ticket_saturated)
                  report_mismatch("ticket_saturated", seen.ticket_saturated,
                                  want.ticket_saturated);
            end
         end
      end
   end

   // Hand the lock around among requesters at the reset thread count.
   task automatic test_lock_handoff();
      send_item(FUNC_RELEASE, 3'd0);   // release with no request pending
      send_item(FUNC_REQUEST, 3'd0);
      send_item(FUNC_REQUEST, 3'd7);
      send_item(FUNC_REQUEST, 3'd3);
      send_item(FUNC_RELEASE, 3'd0);
      send_item(FUNC_REQUEST, 3'd0);
      send_item(FUNC_RELEASE, 3'd7);
      send_item(FUNC_RELEASE, 3'd3);
      send_item(FUNC_RELEASE, 3'd0);
   endtask

   // Thread count extremes, ignored requesters, inactive entries and the spare address.
   task automatic test_thread_count_limits();
      set_register(THREAD_COUNT_ADDR, 32'd0);
      send_item(FUNC_REQUEST, 3'd0);
      send_item(FUNC_RELEASE, 3'd7);
      set_register(THREAD_COUNT_ADDR, 32'hFFFF_FFFF);
      send_item(FUNC_REQUEST, 3'd7);
      send_item(FUNC_REQUEST, 3'd6);
      set_register(THREAD_COUNT_ADDR, 32'd1);
      send_item(FUNC_REQUEST, 3'd0);
      send_item(FUNC_REQUEST, 3'd1);
      send_item(FUNC_RELEASE, 3'd7);
      set_register(SPARE_ADDR, 32'd2);
      send_item(FUNC_REQUEST, 3'd1);
      set_register(THREAD_COUNT_ADDR, 32'd8);
      send_item(FUNC_RELEASE, 3'd0);
      send_item(FUNC_RELEASE, 3'd7);
      send_item(FUNC_RELEASE, 3'd6);
   endtask

   // Mostly lock traffic to active requesters, some noise to inactive ones.
   task automatic send_random_lock_item();
      logic [2:0]  tid;
      func_type    f;
      int unsigned active;
      active = active_threads();
      if (active != 0 && $urandom_range(99) < 85) tid = 3'($urandom_range(active - 1));
      else tid = 3'($urandom_range(NUM_THREADS - 1));
      if (wants_lock[tid]) f = ($urandom_range(3) == 0) ? FUNC_REQUEST : FUNC_RELEASE;
      else f = ($urandom_range(3) == 0) ? FUNC_RELEASE : FUNC_REQUEST;
      send_item(f, tid);
   endtask

   // Random phases, each after a register write, most of them to the thread count; both idling mixes.
   task automatic test_random_traffic();
      int unsigned useful;
      int unsigned pick;
      int unsigned phase_len;
      useful = 0;
      while (useful < 420) begin
         if (useful >= 210) set_idling(58, 34);
         pick = $urandom_range(19);
         if (pick == 0) set_register(THREAD_COUNT_ADDR, {28'($urandom), 4'd0});
         else if (pick == 1)
            set_register(THREAD_COUNT_ADDR, {28'($urandom), 4'($urandom_range(15, 9))});
         else if (pick == 2) set_register(SPARE_ADDR, $urandom);
         else set_register(THREAD_COUNT_ADDR, {28'd0, 4'($urandom_range(8, 1))});
         phase_len = $urandom_range(40, 10);
         repeat (phase_len) begin
            send_random_lock_item();
            if (!pending_reports[$].ignored) useful++;
         end
      end
   endtask

   // Hold the response side off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      set_register(THREAD_COUNT_ADDR, 32'd8);
      -> hold_off_start;
      repeat (40) send_random_lock_item();
   endtask

   // Grow one requester's ticket alone, then bring the stale entries back into the scan.
   task automatic test_stale_tickets();
      set_register(THREAD_COUNT_ADDR, 32'd1);
      repeat (4) send_item(FUNC_REQUEST, 3'd0);
      set_register(THREAD_COUNT_ADDR, 32'd3);
      send_item(FUNC_REQUEST, 3'd2);
      send_item(FUNC_REQUEST, 3'd1);
      send_item(FUNC_RELEASE, 3'd0);
      send_item(FUNC_RELEASE, 3'd1);
      set_register(THREAD_COUNT_ADDR, 32'd8);
      send_item(FUNC_REQUEST, 3'd7);
      send_item(FUNC_RELEASE, 3'd2);
   endtask

   // Reset, run each test in turn, then drain and report.
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_REQUEST;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      cfg_thread_count = THREAD_COUNT_RESET;
      for (int k = 0; k < NUM_THREADS; k++) begin
         wants_lock[k] = 1'b0;
         held_ticket[k] = '0;
      end
      set_idling(34, 58);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      read_back_thread_count();
      test_lock_handoff();
      test_thread_count_limits();
      test_random_traffic();
      set_idling(0, 0);
      test_backpressure();
      test_stale_tickets();

      wait_idle();
      repeat (50) @(posedge clock);
      if (pending_reports.size() != 0)
         report_mismatch("owner reports never returned", pending_reports.size(), 0);

      $display("covered %0d lock transactions, %0d ignored and %0d with a saturated ticket,",
               items_sent, ignored_items, saturated_tickets);
      $display("over %0d register writes, with %0d request-side stall cycles",
               register_writes, input_stall_cycles);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/bta_pkg.sv
rtl/bakery_ticket_arbiter_top.sv
tb/tb_bakery_ticket_arbiter_top.sv
